// ===== hdl/matrix_multiply_core_macros.svh =====
// Assertion macros for the matrix multiply core.
// Used by files that hold concurrent checks; expects clk and rst in scope.
`ifndef MATRIX_MULTIPLY_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define MMC_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define MMC_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/mmc_pkg.sv =====
// Shared types, constants and helper functions of the matrix multiply core.
// No dependencies; imported by every module of the block.
package mmc_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int CNT_W   = 4;
  localparam int VAL_W   = 32;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int ACC_W   = PROD_W + IDX_W;
  localparam int FRAC_W  = 16;
  localparam int SH_W    = ACC_W - FRAC_W;

  // Opcodes of an input transaction
  localparam logic [1:0] OP_WRITE_A  = 2'd0;
  localparam logic [1:0] OP_WRITE_B  = 2'd1;
  localparam logic [1:0] OP_MULTIPLY = 2'd2;

  // Result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_INDEX = 2'd1;
  localparam logic [1:0] STATUS_DIM   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  // Tag carried alongside each multiply-accumulate step
  typedef struct packed {
    logic             first;
    logic             last_t;
    logic             last_el;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  // Finished product element from the datapath
  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } result_t;

  // Highest usable index for a dimension register: 0 acts as 1, above MAX_DIM as MAX_DIM
  function automatic logic [IDX_W-1:0] dim_last(input logic [CNT_W-1:0] r);
    logic [IDX_W-1:0] res;
    if (r == '0) begin
      res = '0;
    end else if (r > CNT_W'(MAX_DIM)) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(r - 1'b1);
    end
    return res;
  endfunction

  // Store address, row-major
  function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return {row, col};
  endfunction

  // Rescale Q35.32 sum to Q16.16 (floor) and saturate to 32 bits
  function automatic logic signed [VAL_W-1:0] rescale_sat(input logic signed [ACC_W-1:0] acc);
    logic [SH_W-1:0] sh;
    logic signed [VAL_W-1:0] res;
    sh = acc[ACC_W-1:FRAC_W];
    if (&sh[SH_W-1:VAL_W-1] || ~|sh[SH_W-1:VAL_W-1]) begin
      res = sh[VAL_W-1:0];
    end else if (sh[SH_W-1]) begin
      res = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(VAL_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// ===== hdl/mmc_seq.sv =====
// Multiply sequencer: walks row, column and inner index, issuing store reads.
// Depends on mmc_pkg.
module mmc_seq (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         pipe_en,
  input  logic [mmc_pkg::IDX_W-1:0]    ar_last,
  input  logic [mmc_pkg::IDX_W-1:0]    ac_last,
  input  logic [mmc_pkg::IDX_W-1:0]    bc_last,
  output logic                         issue,
  output mmc_pkg::tag_t                tag,
  output logic [mmc_pkg::ADDR_W-1:0]   addr_a,
  output logic [mmc_pkg::ADDR_W-1:0]   addr_b,
  output logic                         running
);
  import mmc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state;
  logic [IDX_W-1:0] i_cnt;
  logic [IDX_W-1:0] j_cnt;
  logic [IDX_W-1:0] t_cnt;

  assign running = (state == S_RUN);
  assign issue   = running && pipe_en;

  // Tag and read addresses for the current step
  always_comb begin
    tag.first   = (t_cnt == '0);
    tag.last_t  = (t_cnt == ac_last);
    tag.last_el = (t_cnt == ac_last) && (i_cnt == ar_last) && (j_cnt == bc_last);
    tag.row     = i_cnt;
    tag.col     = j_cnt;
    addr_a      = elem_addr(i_cnt, t_cnt);
    addr_b      = elem_addr(t_cnt, j_cnt);
  end

  // Loop counters and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      t_cnt <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            i_cnt <= '0;
            j_cnt <= '0;
            t_cnt <= '0;
          end
        end
        S_RUN: begin
          if (pipe_en) begin
            if (tag.last_el) begin
              state <= S_IDLE;
            end
            if (tag.last_t) begin
              t_cnt <= '0;
              if (j_cnt == bc_last) begin
                j_cnt <= '0;
                i_cnt <= i_cnt + 1'b1;
              end else begin
                j_cnt <= j_cnt + 1'b1;
              end
            end else begin
              t_cnt <= t_cnt + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/mmc_dp.sv =====
// Datapath: A and B element stores, multiplier and accumulator pipeline.
// Depends on mmc_pkg.
module mmc_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pipe_en,
  input  logic                              issue,
  input  mmc_pkg::tag_t                     tag,
  input  logic [mmc_pkg::ADDR_W-1:0]        addr_a,
  input  logic [mmc_pkg::ADDR_W-1:0]        addr_b,
  input  logic                              wr_a,
  input  logic                              wr_b,
  input  logic [mmc_pkg::ADDR_W-1:0]        wr_addr,
  input  logic signed [mmc_pkg::VAL_W-1:0]  wr_data,
  output logic                              busy,
  output mmc_pkg::result_t                  res
);
  import mmc_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;

  logic [VAL_W-1:0] store_a [DEPTH];
  logic [VAL_W-1:0] store_b [DEPTH];

  logic                     s1_v;
  tag_t                     s1_tag;
  logic [VAL_W-1:0]         rd_a;
  logic [VAL_W-1:0]         rd_b;
  logic                     s2_v;
  tag_t                     s2_tag;
  logic signed [PROD_W-1:0] prod;
  logic                     s3_v;
  tag_t                     s3_tag;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_base;

  // Store A: written while idle, read one step per cycle during a multiply unless pipe_en stalls it
  always_ff @(posedge clk) begin
    if (wr_a) begin
      store_a[wr_addr] <= wr_data;
    end
    if (pipe_en) begin
      rd_a <= store_a[addr_a];
    end
  end

  // Store B
  always_ff @(posedge clk) begin
    if (wr_b) begin
      store_b[wr_addr] <= wr_data;
    end
    if (pipe_en) begin
      rd_b <= store_b[addr_b];
    end
  end

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (pipe_en) begin
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v && s2_tag.last_t;
    end
  end

  // Product, then exact accumulation from zero
  assign acc_base = s2_tag.first ? ACC_W'(0) : acc;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_tag <= tag;
      s2_tag <= s1_tag;
      prod   <= $signed(rd_a) * $signed(rd_b);
      if (s2_v) begin
        acc    <= acc_base + ACC_W'(prod);
        s3_tag <= s2_tag;
      end
    end
  end

  assign busy      = s1_v || s2_v || s3_v;
  assign res.valid = s3_v;
  assign res.row   = s3_tag.row;
  assign res.col   = s3_tag.col;
  assign res.value = rescale_sat(acc);
  assign res.last  = s3_tag.last_el;

endmodule

// ===== hdl/matrix_multiply_core.sv =====
// Matrix multiply core: an element write acknowledge passes through the final stage
// and the output register after acceptance. A multiply takes one multiply-accumulate
// per cycle while the output does not stall the pipeline; each element store has a single read port.
// Writes and commands are taken one at a time; a result waiting at the output
// does not block the next transaction. Reset clears control state and sets all
// dimension registers to 1; store contents are not cleared.
`include "matrix_multiply_core_macros.svh"

module matrix_multiply_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [1:0]                        cfg_index,
  input  logic [mmc_pkg::CNT_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic [mmc_pkg::IDX_W-1:0]         row_index,
  input  logic [mmc_pkg::IDX_W-1:0]         col_index,
  input  logic signed [mmc_pkg::VAL_W-1:0]  element_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mmc_pkg::IDX_W-1:0]         out_row,
  output logic [mmc_pkg::IDX_W-1:0]         out_col,
  output logic signed [mmc_pkg::VAL_W-1:0]  out_value,
  output logic [1:0]                        status,
  output logic                              last
);
  import mmc_pkg::*;

  logic [CNT_W-1:0]        a_row_count;
  logic [CNT_W-1:0]        a_col_count;
  logic [CNT_W-1:0]        b_row_count;
  logic [CNT_W-1:0]        b_col_count;
  logic [IDX_W-1:0]        ar_last;
  logic [IDX_W-1:0]        ac_last;
  logic [IDX_W-1:0]        br_last;
  logic [IDX_W-1:0]        bc_last;

  logic                    in_fire;
  logic                    is_wr;
  logic                    idx_ok;
  logic                    dims_ok;
  logic                    wr_a;
  logic                    wr_b;
  logic                    start;
  logic                    ack_load;
  logic                    out_take;
  logic                    pipe_en;
  logic                    running;
  logic                    busy;
  logic                    issue;
  tag_t                    tag;
  logic [ADDR_W-1:0]       addr_a;
  logic [ADDR_W-1:0]       addr_b;
  result_t                 res;

  logic                    fin_v;
  logic [IDX_W-1:0]        fin_row;
  logic [IDX_W-1:0]        fin_col;
  logic signed [VAL_W-1:0] fin_value;
  logic [1:0]              fin_status;
  logic                    fin_last;

  // Dimension registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_row_count <= CNT_W'(1);
      a_col_count <= CNT_W'(1);
      b_row_count <= CNT_W'(1);
      b_col_count <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_A_ROWS: a_row_count <= cfg_data;
        REG_A_COLS: a_col_count <= cfg_data;
        REG_B_ROWS: b_row_count <= cfg_data;
        REG_B_COLS: b_col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ar_last = dim_last(a_row_count);
  assign ac_last = dim_last(a_col_count);
  assign br_last = dim_last(b_row_count);
  assign bc_last = dim_last(b_col_count);

  // Input decode
  assign in_ready = !running && !busy && !fin_v;
  assign in_fire  = in_valid && in_ready;
  assign is_wr    = (opcode == OP_WRITE_A) || (opcode == OP_WRITE_B);
  assign idx_ok   = (opcode == OP_WRITE_A) ?
                    ((row_index <= ar_last) && (col_index <= ac_last)) :
                    ((row_index <= br_last) && (col_index <= bc_last));
  assign dims_ok  = (ac_last == br_last);
  assign wr_a     = in_fire && (opcode == OP_WRITE_A) && idx_ok;
  assign wr_b     = in_fire && (opcode == OP_WRITE_B) && idx_ok;
  assign start    = in_fire && (opcode == OP_MULTIPLY) && dims_ok;
  assign ack_load = in_fire && (is_wr || ((opcode == OP_MULTIPLY) && !dims_ok));

  // Flow control: the pipeline moves whenever the final stage is empty or can drain
  assign out_take = !out_valid || out_ready;
  assign pipe_en  = !fin_v || out_take;

  mmc_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .pipe_en (pipe_en),
    .ar_last (ar_last),
    .ac_last (ac_last),
    .bc_last (bc_last),
    .issue   (issue),
    .tag     (tag),
    .addr_a  (addr_a),
    .addr_b  (addr_b),
    .running (running)
  );

  mmc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .pipe_en (pipe_en),
    .issue   (issue),
    .tag     (tag),
    .addr_a  (addr_a),
    .addr_b  (addr_b),
    .wr_a    (wr_a),
    .wr_b    (wr_b),
    .wr_addr (elem_addr(row_index, col_index)),
    .wr_data (element_value),
    .busy    (busy),
    .res     (res)
  );

  // Final stage: product element or acknowledge transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_v <= 1'b0;
    end else if (pipe_en) begin
      fin_v <= res.valid || ack_load;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      if (ack_load) begin
        fin_row    <= is_wr ? row_index : '0;
        fin_col    <= is_wr ? col_index : '0;
        fin_value  <= '0;
        fin_status <= is_wr ? (idx_ok ? STATUS_OK : STATUS_INDEX) : STATUS_DIM;
        fin_last   <= 1'b1;
      end else begin
        fin_row    <= res.row;
        fin_col    <= res.col;
        fin_value  <= res.value;
        fin_status <= STATUS_OK;
        fin_last   <= res.last;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_row   <= fin_row;
      out_col   <= fin_col;
      out_value <= fin_value;
      status    <= fin_status;
      last      <= fin_last;
    end
  end

  // Checks
  `MMC_CHECK_NOW(a_no_store_write_in_run, wr_a || wr_b, !running && !busy, "store written during multiply")
  `MMC_CHECK_NEXT(a_start_runs, start, running, "multiply did not start")
  `MMC_CHECK_NOW(a_dim_error_form, out_valid && (status == STATUS_DIM), last && (out_value == '0) && (out_row == '0) && (out_col == '0), "malformed dimension error")

endmodule
